// File: src/wsrr_pkg.sv
// ----------------------------------------------------------------------------
// wsrr_pkg
// Types and constants shared by the sparse row reduction modules.
// ----------------------------------------------------------------------------
package wsrr_pkg;

	localparam int TABLE_DEPTH_DEF      = 4096;
	localparam int ACCUMULATOR_BITS_DEF = 48;

	localparam int CMD_W      = 2;
	localparam int FEATURE_W  = 12;
	localparam int VALUE_W    = 16;
	localparam int PRODUCT_W  = 2 * VALUE_W;
	localparam int ROW_W      = 20;
	localparam int ROW_SUM_W  = 48;
	localparam int WIDE_W     = 64;

	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PW    = $clog2(OUTQ_DEPTH);

	localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ENTRY   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_END_ROW = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]            command;
		logic [FEATURE_W-1:0]        feature_index;
		logic signed [VALUE_W-1:0]   entry_value;
		logic                        last_in_row;
	} entry_t;

	typedef struct packed {
		logic [ROW_W-1:0]            row_index;
		logic signed [ROW_SUM_W-1:0] row_sum;
		logic                        saturated;
	} result_t;

	// row-end items still in the pipeline
	typedef struct packed {
		logic s1;
		logic s2;
	} pend_t;

endpackage

// File: src/weighted_sparse_row_reduction_core.sv
// ----------------------------------------------------------------------------
// weighted_sparse_row_reduction_core
// CSR sparse matrix times weight vector with saturating Q16 row sums.
//
// Input channel (entry_valid / entry_stall / entry) takes one item per cycle
// while entry_stall is low: a weight load, a matrix entry, or an end-row
// command. Entries read their weight from a single-port table RAM; the Q16.16
// product is registered in stage s2 and then added to the row accumulator.
// Result channel (result_valid / result_stall / result) carries one item
// per finished row; a row end passes stages s1 and s2 before its result
// is queued. Throughput, while not stalled, is one item per cycle, set by the
// single RAM port and the one multiply-accumulate per cycle.
// Results wait in a 4-entry queue; entry_stall rises when queued results
// plus row ends still in the pipeline reach 4, so a stalled receiver
// backs up the input after at most 4 rows.
// Reset clears the accumulator, the saturation flag and the row counter.
// The weight table is not cleared: load every weight before it is used.
// ----------------------------------------------------------------------------
module weighted_sparse_row_reduction_core
	import wsrr_pkg::*;
#(
	parameter int TABLE_DEPTH      = TABLE_DEPTH_DEF,
	parameter int ACCUMULATOR_BITS = ACCUMULATOR_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    entry_valid,
	output logic    entry_stall,
	input  entry_t  entry,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic                    accept;
	logic                    hit;
	logic [AW+FEATURE_W-1:0] fi_wide;
	logic [AW-1:0]           addr;
	logic                    we;
	logic [VALUE_W-1:0]      weight;
	logic                    res_valid;
	result_t                 res;
	pend_t                   pend;
	logic [OUTQ_PW:0]        q_count;
	logic [OUTQ_PW+1:0]      occ;

	assign accept  = entry_valid && !entry_stall;
	assign hit     = 32'(entry.feature_index) < 32'(TABLE_DEPTH);
	assign fi_wide = (AW+FEATURE_W)'(entry.feature_index);
	assign addr    = fi_wide[AW-1:0];
	assign we      = accept && (entry.command == CMD_LOAD) && hit;

	wsrr_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (TABLE_DEPTH)
	) u_weights (
		.clk   (clk),
		.en    (accept),
		.we    (we),
		.addr  (addr),
		.wdata (entry.entry_value),
		.rdata (weight)
	);

	wsrr_mac #(
		.ACCUMULATOR_BITS (ACCUMULATOR_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (accept),
		.item      (entry),
		.hit       (hit),
		.weight    (weight),
		.res_valid (res_valid),
		.res       (res),
		.pend      (pend)
	);

	wsrr_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.valid     (result_valid),
		.stall     (result_stall),
		.data      (result),
		.count     (q_count)
	);

	assign occ = (OUTQ_PW+2)'(q_count) + (OUTQ_PW+2)'(pend.s1) + (OUTQ_PW+2)'(pend.s2);
	assign entry_stall = occ >= (OUTQ_PW+2)'(OUTQ_DEPTH);

endmodule

// File: src/wsrr_ram.sv
// ----------------------------------------------------------------------------
// wsrr_ram
// Generic single-port RAM, write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module wsrr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: src/wsrr_mac.sv
// ----------------------------------------------------------------------------
// wsrr_mac
// Multiply stage and saturating row accumulator with row counter.
// ----------------------------------------------------------------------------
module wsrr_mac
	import wsrr_pkg::*;
#(
	parameter int ACCUMULATOR_BITS = ACCUMULATOR_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                issue,
	input  entry_t              item,
	input  logic                hit,
	input  logic [VALUE_W-1:0]  weight,
	output logic                res_valid,
	output result_t             res,
	output pend_t               pend
);

	localparam int AB = ACCUMULATOR_BITS;

	logic                       v_s1;
	logic [CMD_W-1:0]           cmd_s1;
	logic signed [VALUE_W-1:0]  val_s1;
	logic                       last_s1;
	logic                       hit_s1;

	logic                       v_s2;
	logic [CMD_W-1:0]           cmd_s2;
	logic                       last_s2;
	logic signed [PRODUCT_W-1:0] prod_s2;

	logic signed [AB-1:0]       acc_q;
	logic                       sat_q;
	logic [ROW_W-1:0]           row_q;

	logic signed [VALUE_W-1:0]  wgt;
	logic signed [PRODUCT_W-1:0] prod;
	logic signed [AB:0]         sum;
	logic                       ovf;
	logic                       add_en;
	logic                       row_end;
	logic signed [AB-1:0]       acc_add;
	logic signed [AB-1:0]       acc_nx;
	logic                       sat_nx;
	logic signed [WIDE_W-1:0]   acc_wide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1  <= item.command;
		val_s1  <= item.entry_value;
		last_s1 <= item.last_in_row;
		hit_s1  <= hit;
		cmd_s2  <= cmd_s1;
		last_s2 <= last_s1;
		prod_s2 <= prod;
	end

	// out-of-range features use weight zero
	assign wgt  = hit_s1 ? $signed(weight) : '0;
	assign prod = val_s1 * wgt;

	assign add_en  = v_s2 && (cmd_s2 == CMD_ENTRY);
	assign row_end = v_s2 && ((cmd_s2 == CMD_END_ROW) ||
		((cmd_s2 == CMD_ENTRY) && last_s2));

	assign sum = (AB+1)'(acc_q) + (AB+1)'(prod_s2);
	assign ovf = sum[AB] ^ sum[AB-1];

	always_comb begin
		if (!ovf) begin
			acc_add = sum[AB-1:0];
		end else if (sum[AB]) begin
			acc_add = {1'b1, {(AB-1){1'b0}}};
		end else begin
			acc_add = {1'b0, {(AB-1){1'b1}}};
		end
	end

	assign acc_nx   = add_en ? acc_add : acc_q;
	assign sat_nx   = sat_q | (add_en & ovf);
	assign acc_wide = WIDE_W'(acc_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			sat_q <= 1'b0;
			row_q <= '0;
		end else if (row_end) begin
			acc_q <= '0;
			sat_q <= 1'b0;
			row_q <= row_q + ROW_W'(1);
		end else begin
			acc_q <= acc_nx;
			sat_q <= sat_nx;
		end
	end

	assign res_valid     = row_end;
	assign res.row_index = row_q;
	assign res.row_sum   = acc_wide[ROW_SUM_W-1:0];
	assign res.saturated = sat_nx;

	assign pend.s1 = v_s1 && ((cmd_s1 == CMD_END_ROW) ||
		((cmd_s1 == CMD_ENTRY) && last_s1));
	assign pend.s2 = row_end;

endmodule

// File: src/wsrr_outq.sv
// ----------------------------------------------------------------------------
// wsrr_outq
// Small result queue between the accumulator and the result channel.
// ----------------------------------------------------------------------------
module wsrr_outq
	import wsrr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  result_t            push_data,
	output logic               valid,
	input  logic               stall,
	output result_t            data,
	output logic [OUTQ_PW:0]   count
);

	result_t              buf_q [OUTQ_DEPTH];
	logic [OUTQ_PW-1:0]   wr_q;
	logic [OUTQ_PW-1:0]   rd_q;
	logic [OUTQ_PW:0]     cnt_q;
	logic                 pop;

	assign valid = (cnt_q != '0);
	assign data  = buf_q[rd_q];
	assign pop   = valid && !stall;
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + OUTQ_PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + OUTQ_PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (OUTQ_PW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (OUTQ_PW+1)'(1);
			end
		end
	end

endmodule

// File: test/wsrr_row_sum_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wsrr_row_sum_checker
// Watches both channels of the row reduction core and checks every row result.
//
// Keeps its own weight table, saturating Q16 row sum and row number. Each
// accepted load, entry or end-row item updates them. Each row end queues
// the expected row result. Each accepted result is compared with the oldest
// queued row. Mismatches and unexpected results add to error_count.
// rows_pending tells the test top how many rows are still owed.
// ----------------------------------------------------------------------------
module wsrr_row_sum_checker
	import wsrr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    entry_valid,
	input  logic    entry_stall,
	input  entry_t  entry,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result,
	output int      error_count,
	output int      rows_pending,
	output int      rows_checked
);

	localparam longint SUM_MAX = (longint'(1) <<< (ROW_SUM_W - 1)) - 1;
	localparam longint SUM_MIN = -SUM_MAX - 1;

	logic signed [VALUE_W-1:0]   weight_mem [TABLE_DEPTH_DEF];
	logic signed [ROW_SUM_W-1:0] row_acc;
	logic [ROW_W-1:0]            row_no;
	logic                        row_sat;
	result_t                     expected_rows [$];

	task automatic close_row();
		result_t row;
		row.row_index = row_no;
		row.row_sum   = row_acc;
		row.saturated = row_sat;
		expected_rows.push_back(row);
		row_acc = '0;
		row_sat = 1'b0;
		row_no  = row_no + ROW_W'(1);
	endtask

	task automatic add_product(input logic signed [PRODUCT_W-1:0] prod);
		longint sum;
		sum = longint'(row_acc) + longint'(prod);
		if (sum > SUM_MAX) begin
			row_acc = SUM_MAX[ROW_SUM_W-1:0];
			row_sat = 1'b1;
		end else if (sum < SUM_MIN) begin
			row_acc = SUM_MIN[ROW_SUM_W-1:0];
			row_sat = 1'b1;
		end else begin
			row_acc = sum[ROW_SUM_W-1:0];
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t                     want;
		logic signed [PRODUCT_W-1:0] prod;
		if (!arst_n) begin
			row_acc      = '0;
			row_no       = '0;
			row_sat      = 1'b0;
			error_count  = 0;
			rows_checked = 0;
			expected_rows.delete();
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_rows.size() == 0) begin
					$error("unexpected row result: row_index %0d, row_sum %0d",
						result.row_index, result.row_sum);
					error_count++;
				end else begin
					want = expected_rows.pop_front();
					rows_checked++;
					if (result.row_index !== want.row_index) begin
						$error("row_index: expected %0d, got %0d",
							want.row_index, result.row_index);
						error_count++;
					end
					if (result.row_sum !== want.row_sum) begin
						$error("row_sum: expected %0d, got %0d",
							want.row_sum, result.row_sum);
						error_count++;
					end
					if (result.saturated !== want.saturated) begin
						$error("saturated: expected %0d, got %0d",
							want.saturated, result.saturated);
						error_count++;
					end
				end
			end
			if (entry_valid && !entry_stall) begin
				case (entry.command)
					CMD_LOAD: begin
						weight_mem[entry.feature_index] = entry.entry_value;
					end
					CMD_ENTRY: begin
						prod = entry.entry_value * weight_mem[entry.feature_index];
						add_product(prod);
						if (entry.last_in_row)
							close_row();
					end
					CMD_END_ROW: begin
						close_row();
					end
					default: ;
				endcase
			end
		end
		rows_pending = expected_rows.size();
	end

endmodule

// File: test/weighted_sparse_row_reduction_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_sparse_row_reduction_core_test
// Stimulus and verdict for the CSR row reduction core.
//
// A short directed set covers extreme weights and values, an empty row, the
// ignored command and a marked load. Random well-formed rows with noise
// follow, with random idling on both sides, a long receiver hold-off and a
// drain pause. The checker beside the core predicts and compares every
// row result.
// ----------------------------------------------------------------------------
module weighted_sparse_row_reduction_core_test;
	import wsrr_pkg::*;

	localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
	localparam int QUIET_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_ITEMS  = 420;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    entry_valid  = 1'b0;
	logic    entry_stall;
	entry_t  entry        = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	int error_count;
	int rows_pending;
	int rows_checked;

	bit          tx_idle_en = 1'b1;
	bit          rx_idle_en = 1'b1;
	int unsigned hold_req   = 0;
	int unsigned hold_ack   = 0;
	int unsigned hold_left  = 0;
	int unsigned quiet_cycles = 0;
	int unsigned items_sent = 0;
	int unsigned noise_sent = 0;

	bit weight_loaded [TABLE_DEPTH_DEF];
	int loaded_features [$];

	always #5 clk = ~clk;

	weighted_sparse_row_reduction_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry_valid  (entry_valid),
		.entry_stall  (entry_stall),
		.entry        (entry),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	wsrr_row_sum_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry_valid  (entry_valid),
		.entry_stall  (entry_stall),
		.entry        (entry),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.error_count  (error_count),
		.rows_pending (rows_pending),
		.rows_checked (rows_checked)
	);

	// receiver: random stalls plus requested hold-offs
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req != hold_ack) begin
				hold_ack  = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= rx_idle_en && ($urandom_range(99) < 16);
			end
		end
	end

	always @(posedge clk) begin
		if ((entry_valid && !entry_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("weighted_sparse_row_reduction_core_test: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic entry_t make_item(input logic [CMD_W-1:0] cmd,
		input logic [FEATURE_W-1:0] feat, input logic [VALUE_W-1:0] val,
		input logic last);
		entry_t it;
		it.command       = cmd;
		it.feature_index = feat;
		it.entry_value   = val;
		it.last_in_row   = last;
		return it;
	endfunction

	function automatic logic [VALUE_W-1:0] rand_value();
		case ($urandom_range(7))
			0:       return 16'h7fff;
			1:       return 16'h8000;
			2:       return 16'h0000;
			default: return VALUE_W'($urandom);
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input entry_t item);
		while (tx_idle_en && $urandom_range(99) < 16) begin
			entry_valid <= 1'b0;
			@(negedge clk);
		end
		entry_valid <= 1'b1;
		entry       <= item;
		@(posedge clk);
		while (entry_stall)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_noise_end_row();
		send_item(make_item(CMD_END_ROW, FEATURE_W'($urandom), VALUE_W'($urandom),
			1'($urandom)));
	endtask

	task automatic load_weight(input logic [FEATURE_W-1:0] feat,
		input logic [VALUE_W-1:0] val, input logic last);
		send_item(make_item(CMD_LOAD, feat, val, last));
		if (!weight_loaded[feat]) begin
			weight_loaded[feat] = 1'b1;
			loaded_features.push_back(int'(feat));
		end
	endtask

	task automatic send_random_row();
		int  len;
		bit  close_cmd;
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(3, 1))
				load_weight(FEATURE_W'($urandom_range(TABLE_DEPTH_DEF - 1)),
					rand_value(), 1'($urandom));
		if ($urandom_range(19) == 0) begin
			send_item(make_item(CMD_IGNORED, FEATURE_W'($urandom), VALUE_W'($urandom),
				1'($urandom)));
			noise_sent++;
		end
		len       = $urandom_range(6);
		close_cmd = ($urandom_range(4) == 0);
		for (int i = 0; i < len; i++)
			send_item(make_item(CMD_ENTRY,
				FEATURE_W'(loaded_features[$urandom_range(loaded_features.size() - 1)]),
				rand_value(), (i == len - 1) && !close_cmd));
		if (len == 0 || close_cmd)
			send_noise_end_row();
	endtask

	initial begin
		int unsigned random_start;
		int          rows_started;

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, empty row, marked load, ignored command
		load_weight(12'h000, 16'h7fff, 1'b0);
		load_weight(12'hfff, 16'h8000, 1'b1);
		load_weight(12'haaa, 16'h5555, 1'b0);
		load_weight(12'h555, 16'haaaa, 1'b0);
		load_weight(12'h001, 16'h0100, 1'b0);
		load_weight(12'h002, 16'hffff, 1'b0);
		send_item(make_item(CMD_END_ROW, 12'h000, 16'h0000, 1'b0));
		send_item(make_item(CMD_ENTRY, 12'h000, 16'h7fff, 1'b0));
		send_item(make_item(CMD_ENTRY, 12'hfff, 16'h8000, 1'b0));
		send_item(make_item(CMD_ENTRY, 12'h001, 16'h8000, 1'b1));
		send_item(make_item(CMD_IGNORED, 12'hfff, 16'hffff, 1'b1));
		noise_sent++;
		send_item(make_item(CMD_ENTRY, 12'haaa, 16'h0000, 1'b1));
		send_item(make_item(CMD_ENTRY, 12'h555, 16'h7fff, 1'b0));
		send_item(make_item(CMD_END_ROW, 12'hfff, 16'h8000, 1'b1));
		send_item(make_item(CMD_ENTRY, 12'h002, 16'h8000, 1'b1));

		random_start = items_sent - noise_sent;
		rows_started = 0;
		while (items_sent - noise_sent - random_start < RANDOM_ITEMS) begin
			rows_started++;
			if (rows_started == 20) begin
				hold_req++;
				repeat (12)
					send_noise_end_row();
			end
			if (rows_started == 40) begin
				entry_valid <= 1'b0;
				wait (rows_pending == 0);
				@(negedge clk);
			end
			if (rows_started == 50) begin
				tx_idle_en = 1'b0;
				rx_idle_en = 1'b0;
			end
			if (rows_started == 80) begin
				tx_idle_en = 1'b1;
				rx_idle_en = 1'b1;
			end
			send_random_row();
		end
		entry_valid <= 1'b0;

		wait (rows_pending == 0);
		repeat (10) @(posedge clk);
		$display("%0d items sent, %0d rows checked", items_sent, rows_checked);
		$display("covered extreme operands, empty and noisy rows, back-pressure, drain");
		if (error_count == 0 && rows_pending == 0)
			$display("weighted_sparse_row_reduction_core_test: done, clean");
		else
			$display("weighted_sparse_row_reduction_core_test: done, errors");
		$finish;
	end

endmodule

// File: weighted_sparse_row_reduction_core.f
src/wsrr_pkg.sv
src/wsrr_ram.sv
src/wsrr_mac.sv
src/wsrr_outq.sv
src/weighted_sparse_row_reduction_core.sv
test/wsrr_row_sum_checker.sv
test/weighted_sparse_row_reduction_core_test.sv
